>>> rtl/rbd_pkg.sv
`timescale 1ns / 1ps

package rbd_pkg;

  localparam int BYTE_W = 8;
  localparam int CFG_W  = 16;

  // literal flag and count field of a control byte
  localparam int          LIT_BIT    = 7;
  localparam int          CNT_W      = 7;

  // result status codes
  localparam logic [1:0] ST_BUSY    = 2'd0;
  localparam logic [1:0] ST_DONE    = 2'd1;
  localparam logic [1:0] ST_OVERRUN = 2'd2;
  localparam logic [1:0] ST_TRUNC   = 2'd3;

  // result byte counts
  localparam logic [1:0] CNT_NONE = 2'd0;
  localparam logic [1:0] CNT_ONE  = 2'd1;
  localparam logic [1:0] CNT_TWO  = 2'd2;

  typedef struct packed {
    logic       load_len;
    logic       load_run;
    logic       lit_dec;
    logic       val_sub;
    logic       rpt_step;
    logic       emit;
    logic       emit_rpt;
    logic [1:0] emit_cnt;
    logic [1:0] emit_status;
    logic       emit_last;
  } rbd_cmd_t;

  typedef struct packed {
    logic exp_zero;
    logic cnt_gt_left;
    logic run_is_one;
    logic left_is_one;
    logic run_eq_left;
    logic run_ge2;
    logic run_le2;
    logic out_free;
  } rbd_stat_t;

endpackage

>>> rtl/rbd_ctrl.sv
`timescale 1ns / 1ps

module rbd_ctrl
  import rbd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_first,
  input  logic      in_last,
  input  logic      in_lit_flag,
  output logic      in_stall,
  input  rbd_stat_t stat,
  output rbd_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CTRL = 3'd1;
  localparam logic [2:0] S_LIT  = 3'd2;
  localparam logic [2:0] S_VAL  = 3'd3;
  localparam logic [2:0] S_RPT  = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic [2:0] after_r, after_nxt;
  logic [1:0] rpt_st_r, rpt_st_nxt;
  logic       acc;
  logic [2:0] cur;

  assign in_stall = (state_r == S_RPT) || !stat.out_free;
  assign acc      = in_valid && !in_stall;
  assign cur      = in_first ? S_CTRL : state_r;

  always_comb begin
    cmd        = '0;
    state_nxt  = state_r;
    after_nxt  = after_r;
    rpt_st_nxt = rpt_st_r;
    if (acc) begin
      cmd.load_len = in_first;
      if (in_first && stat.exp_zero) begin
        cmd.emit        = 1'b1;
        cmd.emit_cnt    = CNT_NONE;
        cmd.emit_status = ST_DONE;
        cmd.emit_last   = 1'b1;
        state_nxt       = S_IDLE;
      end else begin
        unique case (cur)
          S_CTRL: begin
            if (stat.cnt_gt_left) begin
              cmd.emit        = 1'b1;
              cmd.emit_cnt    = CNT_NONE;
              cmd.emit_status = ST_OVERRUN;
              cmd.emit_last   = 1'b1;
              state_nxt       = S_IDLE;
            end else begin
              cmd.load_run = 1'b1;
              if (in_last) begin
                cmd.emit        = 1'b1;
                cmd.emit_cnt    = CNT_NONE;
                cmd.emit_status = ST_TRUNC;
                cmd.emit_last   = 1'b1;
                state_nxt       = S_IDLE;
              end else begin
                state_nxt = in_lit_flag ? S_LIT : S_VAL;
              end
            end
          end
          S_LIT: begin
            cmd.lit_dec     = 1'b1;
            cmd.emit        = 1'b1;
            cmd.emit_cnt    = CNT_ONE;
            cmd.emit_last   = 1'b1;
            cmd.emit_status = ST_BUSY;
            if (stat.run_is_one && stat.left_is_one) begin
              cmd.emit_status = ST_DONE;
              state_nxt       = S_IDLE;
            end else if (in_last) begin
              cmd.emit_status = ST_TRUNC;
              state_nxt       = S_IDLE;
            end else if (stat.run_is_one) begin
              state_nxt = S_CTRL;
            end
          end
          S_VAL: begin
            cmd.val_sub = 1'b1;
            state_nxt   = S_RPT;
            if (stat.run_eq_left) begin
              rpt_st_nxt = ST_DONE;
              after_nxt  = S_IDLE;
            end else if (in_last) begin
              rpt_st_nxt = ST_TRUNC;
              after_nxt  = S_IDLE;
            end else begin
              rpt_st_nxt = ST_BUSY;
              after_nxt  = S_CTRL;
            end
          end
          default: begin
          end
        endcase
      end
    end else if (state_r == S_RPT && stat.out_free) begin
      cmd.rpt_step    = 1'b1;
      cmd.emit        = 1'b1;
      cmd.emit_rpt    = 1'b1;
      cmd.emit_cnt    = stat.run_ge2 ? CNT_TWO : CNT_ONE;
      cmd.emit_last   = stat.run_le2;
      cmd.emit_status = stat.run_le2 ? rpt_st_r : ST_BUSY;
      if (stat.run_le2) begin
        state_nxt = after_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      after_r  <= S_IDLE;
      rpt_st_r <= ST_BUSY;
    end else begin
      state_r  <= state_nxt;
      after_r  <= after_nxt;
      rpt_st_r <= rpt_st_nxt;
    end
  end

endmodule

>>> rtl/rbd_dp.sv
`timescale 1ns / 1ps

module rbd_dp
  import rbd_pkg::*;
#(
  parameter int LENGTH_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [CFG_W-1:0]  cfg_wr_data,
  input  logic [BYTE_W-1:0] in_byte,
  input  logic              in_first,
  input  rbd_cmd_t          cmd,
  output rbd_stat_t         stat,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [BYTE_W-1:0] out_byte_first,
  output logic [BYTE_W-1:0] out_byte_second,
  output logic [1:0]        out_byte_count,
  output logic [1:0]        out_status,
  output logic              out_last_of_run
);

  logic [CFG_W-1:0]       exp_r;
  logic [LENGTH_BITS-1:0] left_r, left_nxt;
  logic [BYTE_W-1:0]      run_r, run_nxt;
  logic [BYTE_W-1:0]      val_r;
  logic                   out_valid_r;
  logic [BYTE_W-1:0]      b0_r, b1_r;
  logic [1:0]             cnt_r, status_r;
  logic                   last_r;

  logic [LENGTH_BITS-1:0] exp_len, eff_left, run_ext;
  logic [BYTE_W-1:0]      ctl_cnt, src;

  assign exp_len  = LENGTH_BITS'(exp_r);
  assign eff_left = in_first ? exp_len : left_r;
  assign ctl_cnt  = BYTE_W'(in_byte[CNT_W-1:0]) + BYTE_W'(1);
  assign run_ext  = LENGTH_BITS'(run_r);
  assign src      = cmd.emit_rpt ? val_r : in_byte;

  always_comb begin
    stat.exp_zero    = (exp_len == '0);
    stat.cnt_gt_left = (LENGTH_BITS'(ctl_cnt) > eff_left);
    stat.run_is_one  = (run_r == BYTE_W'(1));
    stat.left_is_one = (left_r == LENGTH_BITS'(1));
    stat.run_eq_left = (run_ext == left_r);
    stat.run_ge2     = (run_r >= BYTE_W'(2));
    stat.run_le2     = (run_r <= BYTE_W'(2));
    stat.out_free    = !out_valid_r || !out_stall;
  end

  always_comb begin
    left_nxt = left_r;
    run_nxt  = run_r;
    if (cmd.load_len) left_nxt = exp_len;
    if (cmd.load_run) run_nxt = ctl_cnt;
    if (cmd.lit_dec) begin
      left_nxt = left_r - LENGTH_BITS'(1);
      run_nxt  = run_r - BYTE_W'(1);
    end
    if (cmd.val_sub) left_nxt = left_r - run_ext;
    if (cmd.rpt_step) run_nxt = run_r - (stat.run_ge2 ? BYTE_W'(2) : BYTE_W'(1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_r       <= '0;
      left_r      <= '0;
      run_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) exp_r <= cfg_wr_data;
      left_r <= left_nxt;
      run_r  <= run_nxt;
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.val_sub) val_r <= in_byte;
    if (cmd.emit) begin
      b0_r     <= (cmd.emit_cnt != CNT_NONE) ? src : '0;
      b1_r     <= (cmd.emit_cnt == CNT_TWO) ? src : '0;
      cnt_r    <= cmd.emit_cnt;
      status_r <= cmd.emit_status;
      last_r   <= cmd.emit_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_byte_first  = b0_r;
  assign out_byte_second = b1_r;
  assign out_byte_count  = cnt_r;
  assign out_status      = status_r;
  assign out_last_of_run = last_r;

endmodule

>>> rtl/rle_byte_decoder.sv
`timescale 1ns / 1ps

// channel  direction  handshake             beat
// in_      input      in_valid / in_stall   in_byte, in_first, in_last
// out_     output     out_valid / out_stall byte_first, byte_second, byte_count,
//                                           status, last_of_run
// cfg_     input      cfg_wr_en             cfg_wr_data (expected_bytes)
//
// control and literal bytes pass without stall while the output register is free
// a repeat byte holds the input while its ceil(count / 2) output beats go out,
// paced by the single output register
// synchronous active-low reset returns to idle with expected_bytes at zero
// out_stall holds the output register and, through it, stalls the input

module rle_byte_decoder
  import rbd_pkg::*;
#(
  parameter int LENGTH_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [CFG_W-1:0]  cfg_wr_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [BYTE_W-1:0] in_byte,
  input  logic              in_first,
  input  logic              in_last,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [BYTE_W-1:0] out_byte_first,
  output logic [BYTE_W-1:0] out_byte_second,
  output logic [1:0]        out_byte_count,
  output logic [1:0]        out_status,
  output logic              out_last_of_run
);

  rbd_cmd_t  cmd;
  rbd_stat_t stat;

  rbd_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_first    (in_first),
    .in_last     (in_last),
    .in_lit_flag (in_byte[LIT_BIT]),
    .in_stall    (in_stall),
    .stat        (stat),
    .cmd         (cmd)
  );

  rbd_dp #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_byte         (in_byte),
    .in_first        (in_first),
    .cmd             (cmd),
    .stat            (stat),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte_first  (out_byte_first),
    .out_byte_second (out_byte_second),
    .out_byte_count  (out_byte_count),
    .out_status      (out_status),
    .out_last_of_run (out_last_of_run)
  );

  a_in_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |-> in_stall)
    else $error("input accepted while output register is blocked");

  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_BUSY |-> out_last_of_run)
    else $error("final status on a beat that is not last of run");

  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_byte_count == CNT_NONE |-> out_last_of_run && out_status != ST_BUSY)
    else $error("empty beat without final status");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_byte_count != 2'd3)
    else $error("byte count out of range");

endmodule

>>> sim/rle_byte_decoder_tb.sv
`timescale 1ns / 1ps

module rle_byte_decoder_tb;
  import rbd_pkg::*;

  localparam int QUIET = 8;

  typedef enum logic [1:0] {DP_IDLE, DP_CTRL, DP_LIT, DP_VAL} dec_phase_t;

  typedef struct packed {
    logic [7:0] b0;
    logic [7:0] b1;
    logic [1:0] cnt;
    logic [1:0] st;
    logic       lof;
  } dec_res_t;

  localparam dec_res_t NO_RES = '0;

  typedef struct {
    bit         wr;
    logic [15:0] len;
    logic [7:0] b;
    logic       f;
    logic       l;
    bit         typed;
    dec_res_t   res;
  } dir_row_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_wr_en = 1'b0;
  logic [CFG_W-1:0]  cfg_wr_data = '0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [BYTE_W-1:0] in_byte = '0;
  logic              in_first = 1'b0;
  logic              in_last = 1'b0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [BYTE_W-1:0] out_byte_first;
  logic [BYTE_W-1:0] out_byte_second;
  logic [1:0]        out_byte_count;
  logic [1:0]        out_status;
  logic              out_last_of_run;

  rle_byte_decoder i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_byte         (in_byte),
    .in_first        (in_first),
    .in_last         (in_last),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte_first  (out_byte_first),
    .out_byte_second (out_byte_second),
    .out_byte_count  (out_byte_count),
    .out_status      (out_status),
    .out_last_of_run (out_last_of_run)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // decoder shadow state
  dec_phase_t  dec_phase = DP_IDLE;
  logic [7:0]  run_left = '0;
  logic [15:0] out_left = '0;
  logic [15:0] exp_len = '0;
  bit          took;

  dec_res_t fresh_res[$];
  dec_res_t awaited_res[$];
  dir_row_t dir_rows[$];

  int err_cnt = 0;
  int res_seen = 0;
  int rand_beats = 0;
  int len_sets = 0;
  int burst_left = 0;
  bit vld_on = 1'b0;
  int stall_tick = 0;
  int stall_mode = 0;

  function automatic dec_res_t mk_res(logic [7:0] b0, logic [7:0] b1, logic [1:0] cnt,
                                      logic [1:0] st, logic lof);
    dec_res_t r;
    r.b0 = b0;
    r.b1 = b1;
    r.cnt = cnt;
    r.st = st;
    r.lof = lof;
    return r;
  endfunction

  function automatic void decode_byte(logic [7:0] b, logic f, logic l);
    logic [7:0] cnt;
    logic [7:0] n;
    logic [1:0] st;
    bit         fin;
    fresh_res.delete();
    took = 1'b1;
    if (f) begin
      out_left = exp_len;
      run_left = '0;
      dec_phase = DP_CTRL;
      if (out_left == 0) begin
        dec_phase = DP_IDLE;
        fresh_res.push_back(mk_res(8'h00, 8'h00, CNT_NONE, ST_DONE, 1'b1));
        return;
      end
    end
    case (dec_phase)
      DP_CTRL: begin
        cnt = {1'b0, b[CNT_W-1:0]} + 8'd1;
        if ({8'h00, cnt} > out_left) begin
          dec_phase = DP_IDLE;
          run_left = '0;
          fresh_res.push_back(mk_res(8'h00, 8'h00, CNT_NONE, ST_OVERRUN, 1'b1));
        end else begin
          run_left = cnt;
          dec_phase = b[LIT_BIT] ? DP_LIT : DP_VAL;
          if (l) begin
            dec_phase = DP_IDLE;
            fresh_res.push_back(mk_res(8'h00, 8'h00, CNT_NONE, ST_TRUNC, 1'b1));
          end
        end
      end
      DP_LIT: begin
        st = ST_BUSY;
        out_left = out_left - 16'd1;
        run_left = run_left - 8'd1;
        if (run_left == 0) begin
          if (out_left == 0) begin
            st = ST_DONE;
            dec_phase = DP_IDLE;
          end else begin
            dec_phase = DP_CTRL;
          end
        end
        if (st == ST_BUSY && l) begin
          st = ST_TRUNC;
          dec_phase = DP_IDLE;
        end
        fresh_res.push_back(mk_res(b, 8'h00, CNT_ONE, st, 1'b1));
      end
      DP_VAL: begin
        n = run_left;
        out_left = out_left - {8'h00, run_left};
        run_left = '0;
        if (out_left == 0) begin
          st = ST_DONE;
          dec_phase = DP_IDLE;
        end else if (l) begin
          st = ST_TRUNC;
          dec_phase = DP_IDLE;
        end else begin
          st = ST_BUSY;
          dec_phase = DP_CTRL;
        end
        while (n > 0) begin
          if (n >= 2) begin
            fin = (n == 2);
            fresh_res.push_back(mk_res(b, b, CNT_TWO, fin ? st : ST_BUSY, fin));
            n = n - 8'd2;
          end else begin
            fresh_res.push_back(mk_res(b, 8'h00, CNT_ONE, st, 1'b1));
            n = 8'd0;
          end
        end
      end
      default: took = 1'b0;
    endcase
  endfunction

  function automatic void add_row(bit wr, logic [15:0] len, logic [7:0] b, logic f, logic l,
                                  bit typed, dec_res_t res);
    dir_row_t r;
    r.wr = wr;
    r.len = len;
    r.b = b;
    r.f = f;
    r.l = l;
    r.typed = typed;
    r.res = res;
    dir_rows.push_back(r);
  endfunction

  task automatic report(input string what, input int got, input int want);
    $display("ERROR at %0t ns: %s got 0x%0h want 0x%0h", $time, what, got, want);
    err_cnt++;
  endtask

  task automatic idle_gap();
    int g;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      g = $urandom_range(1, 6);
      in_valid <= 1'b0;
      vld_on = 1'b0;
      repeat (g) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60) : $urandom_range(0, 8);
    end
  endtask

  task automatic feed(input logic [7:0] b, input logic f, input logic l,
                      input bit typed, input dec_res_t res);
    in_valid <= 1'b1;
    vld_on = 1'b1;
    in_byte <= b;
    in_first <= f;
    in_last <= l;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    decode_byte(b, f, l);
    if (typed) begin
      awaited_res.push_back(res);
    end else begin
      foreach (fresh_res[i]) awaited_res.push_back(fresh_res[i]);
    end
    if (took) rand_beats++;
    idle_gap();
  endtask

  task automatic drain();
    if (vld_on) begin
      in_valid <= 1'b0;
      vld_on = 1'b0;
    end
    while (awaited_res.size() != 0) @(posedge clk);
  endtask

  task automatic set_len(input logic [15:0] len);
    drain();
    repeat (QUIET) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= len;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    exp_len = len;
    len_sets++;
  endtask

  // result side: checker plus stall pattern
  always @(posedge clk) begin : rx_side
    dec_res_t want;
    if (rst_n && out_valid && !out_stall) begin
      res_seen++;
      if (awaited_res.size() == 0) begin
        report("result beat with nothing pending, byte_first", int'(out_byte_first), 0);
      end else begin
        want = awaited_res.pop_front();
        if (out_byte_first !== want.b0)
          report("byte_first", int'(out_byte_first), int'(want.b0));
        if (out_byte_second !== want.b1)
          report("byte_second", int'(out_byte_second), int'(want.b1));
        if (out_byte_count !== want.cnt)
          report("byte_count", int'(out_byte_count), int'(want.cnt));
        if (out_status !== want.st)
          report("status", int'(out_status), int'(want.st));
        if (out_last_of_run !== want.lof)
          report("last_of_run", int'(out_last_of_run), int'(want.lof));
      end
    end
    if (stall_tick == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_tick = $urandom_range(20, 80);
    end else begin
      stall_tick--;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= ~out_stall;
    endcase
  end

  initial begin : stim
    int rem;
    int runs;
    int cnt;
    int maxc;
    int r;
    int streams;
    logic [7:0] ctrl;
    logic [15:0] len;
    bit fst;
    bit trunc;
    bit stop;
    bit lst;
    bit paused;

    // idle after reset, then zero length from the reset register value
    add_row(0, 0, 8'h55, 0, 0, 0, NO_RES);
    add_row(0, 0, 8'h00, 1, 0, 1, mk_res(8'h00, 8'h00, CNT_NONE, ST_DONE, 1'b1));
    // largest length: literal pair, longest repeat, truncated literal run
    add_row(1, 16'hFFFF, 8'h81, 1, 0, 0, NO_RES);
    add_row(0, 0, 8'h00, 0, 0, 0, NO_RES);
    add_row(0, 0, 8'hFF, 0, 0, 0, NO_RES);
    add_row(0, 0, 8'h7F, 0, 0, 0, NO_RES);
    add_row(0, 0, 8'hA5, 0, 0, 0, NO_RES);
    add_row(0, 0, 8'hFF, 0, 0, 0, NO_RES);
    add_row(0, 0, 8'h3C, 0, 1, 1, mk_res(8'h3C, 8'h00, CNT_ONE, ST_TRUNC, 1'b1));
    // short length: odd repeat to completion, then ignored byte
    add_row(1, 16'd3, 8'h02, 1, 0, 0, NO_RES);
    add_row(0, 0, 8'h11, 0, 0, 0, NO_RES);
    add_row(0, 0, 8'h22, 0, 0, 0, NO_RES);
    // overrun beats truncation
    add_row(0, 0, 8'h03, 1, 1, 1, mk_res(8'h00, 8'h00, CNT_NONE, ST_OVERRUN, 1'b1));
    add_row(0, 0, 8'h80, 1, 1, 1, mk_res(8'h00, 8'h00, CNT_NONE, ST_TRUNC, 1'b1));
    add_row(0, 0, 8'h01, 1, 0, 0, NO_RES);
    add_row(0, 0, 8'h77, 0, 1, 1, mk_res(8'h77, 8'h77, CNT_TWO, ST_TRUNC, 1'b1));
    // restart in the middle of a literal run
    add_row(0, 0, 8'h82, 1, 0, 0, NO_RES);
    add_row(0, 0, 8'h44, 0, 0, 0, NO_RES);
    add_row(0, 0, 8'h00, 1, 0, 0, NO_RES);
    add_row(0, 0, 8'h99, 0, 0, 0, NO_RES);
    add_row(0, 0, 8'h81, 0, 0, 0, NO_RES);
    add_row(0, 0, 8'h12, 0, 0, 0, NO_RES);
    add_row(0, 0, 8'h34, 0, 1, 0, NO_RES);
    // completion wins over last
    add_row(1, 16'd1, 8'h00, 1, 0, 0, NO_RES);
    add_row(0, 0, 8'hEE, 0, 1, 1, mk_res(8'hEE, 8'h00, CNT_ONE, ST_DONE, 1'b1));
    add_row(0, 0, 8'h80, 1, 0, 0, NO_RES);
    add_row(0, 0, 8'h5A, 0, 1, 1, mk_res(8'h5A, 8'h00, CNT_ONE, ST_DONE, 1'b1));

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].wr) set_len(dir_rows[i].len);
      feed(dir_rows[i].b, dir_rows[i].f, dir_rows[i].l, dir_rows[i].typed, dir_rows[i].res);
    end

    rand_beats = 0;
    streams = 0;
    paused = 1'b0;
    while (rand_beats < 360) begin
      if (streams == 0 || $urandom_range(0, 3) == 0) begin
        r = $urandom_range(0, 19);
        if (r == 0) len = 16'd0;
        else if (r == 1) len = 16'hFFFF;
        else if (r == 2) len = 16'($urandom_range(0, 65535));
        else if (r <= 4) len = 16'($urandom_range(100, 600));
        else len = 16'($urandom_range(1, 40));
        set_len(len);
      end
      streams++;
      if (!paused && rand_beats > 180) begin
        drain();
        paused = 1'b1;
      end
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 8))
          feed(8'($urandom), $urandom_range(0, 5) == 0, $urandom_range(0, 5) == 0, 0, NO_RES);
      end else if (exp_len == 0) begin
        feed(8'($urandom), 1'b1, 1'($urandom_range(0, 1)), 0, NO_RES);
        feed(8'($urandom), 1'b0, 1'($urandom_range(0, 1)), 0, NO_RES);
      end else begin
        rem = int'(exp_len);
        runs = $urandom_range(1, 10);
        fst = 1'b1;
        trunc = ($urandom_range(0, 7) == 0);
        stop = 1'b0;
        while (rem > 0 && runs > 0 && !stop) begin
          maxc = (rem > 128) ? 128 : rem;
          if (maxc > 16 && $urandom_range(0, 7) != 0) maxc = 16;
          if (rem < 128 && $urandom_range(0, 11) == 0) begin
            cnt = $urandom_range(rem + 1, 128);
            stop = 1'b1;
          end else begin
            cnt = $urandom_range(1, maxc);
          end
          ctrl = 8'(cnt - 1);
          ctrl[LIT_BIT] = 1'($urandom_range(0, 1));
          lst = !stop && trunc && ($urandom_range(0, 4) == 0);
          feed(ctrl, fst, lst, 0, NO_RES);
          fst = 1'b0;
          if (lst) stop = 1'b1;
          if (!stop) begin
            if (ctrl[LIT_BIT]) begin
              for (int i = 0; i < cnt && !stop; i++) begin
                rem--;
                lst = (rem == 0) ? 1'($urandom_range(0, 1))
                                 : (trunc && $urandom_range(0, 5) == 0);
                feed(8'($urandom), 1'b0, lst, 0, NO_RES);
                if (lst) stop = 1'b1;
              end
            end else begin
              rem -= cnt;
              lst = (rem == 0) ? 1'($urandom_range(0, 1))
                               : (trunc && $urandom_range(0, 3) == 0);
              feed(8'($urandom), 1'b0, lst, 0, NO_RES);
              if (lst) stop = 1'b1;
            end
          end
          runs--;
        end
        if (rem == 0 && $urandom_range(0, 2) == 0)
          feed(8'($urandom), 1'b0, 1'($urandom_range(0, 1)), 0, NO_RES);
      end
    end

    drain();
    repeat (QUIET * 4) @(posedge clk);
    if (awaited_res.size() != 0) report("results still pending", awaited_res.size(), 0);
    $display("covered %0d directed beats, %0d random beats over %0d streams",
             dir_rows.size(), rand_beats, streams);
    $display("checked %0d result beats across %0d length settings", res_seen, len_sets);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #8000000;
    $display("timeout with %0d results pending", awaited_res.size());
    $display("DONE: errors detected");
    $finish;
  end

endmodule

>>> sim.f
rtl/rbd_pkg.sv
rtl/rbd_ctrl.sv
rtl/rbd_dp.sv
rtl/rle_byte_decoder.sv
sim/rle_byte_decoder_tb.sv
